// ----- rtl/vbm_pkg.sv -----
// Package for the virtio-mmio block register front end.
// Holds the payload types, register offsets and fixed codes; no dependencies.
package vbm_pkg;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [7:0] CFG_DISK_PRESENT = 8'd0;
    localparam logic [7:0] CFG_CAPACITY     = 8'd1;

    localparam logic [31:0] MAGIC_WORD       = 32'h7472_6976;
    localparam logic [31:0] VENDOR_WORD      = 32'h554d_4551;
    localparam logic [31:0] MMIO_VERSION     = 32'd2;
    localparam logic [31:0] BLOCK_DEVICE_ID  = 32'd2;
    localparam int          STATUS_DRIVER_OK = 2;
    localparam logic [3:0]  QUEUE_MAX        = 4'd8;

    localparam logic [11:0] REG_MAGIC        = 12'h000;
    localparam logic [11:0] REG_VERSION      = 12'h004;
    localparam logic [11:0] REG_DEVICE_ID    = 12'h008;
    localparam logic [11:0] REG_VENDOR       = 12'h00c;
    localparam logic [11:0] REG_DEV_FEAT_SEL = 12'h014;
    localparam logic [11:0] REG_DRV_FEAT     = 12'h020;
    localparam logic [11:0] REG_DRV_FEAT_SEL = 12'h024;
    localparam logic [11:0] REG_Q_SEL        = 12'h030;
    localparam logic [11:0] REG_QUEUE_MAX    = 12'h034;
    localparam logic [11:0] REG_QUEUE_SIZE   = 12'h038;
    localparam logic [11:0] REG_Q_READY      = 12'h044;
    localparam logic [11:0] REG_NOTIFY       = 12'h050;
    localparam logic [11:0] REG_INT_STATUS   = 12'h060;
    localparam logic [11:0] REG_INT_ACK      = 12'h064;
    localparam logic [11:0] REG_STATUS       = 12'h070;
    localparam logic [11:0] REG_DESC_LO      = 12'h080;
    localparam logic [11:0] REG_DESC_HI      = 12'h084;
    localparam logic [11:0] REG_AVAIL_LO     = 12'h090;
    localparam logic [11:0] REG_AVAIL_HI     = 12'h094;
    localparam logic [11:0] REG_USED_LO      = 12'h0a0;
    localparam logic [11:0] REG_USED_HI      = 12'h0a4;
    localparam logic [11:0] REG_CAP_LO       = 12'h100;
    localparam logic [11:0] REG_CAP_HI       = 12'h104;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] offset;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        doorbell;
        logic [3:0]  queue_entries;
        logic [63:0] descriptor_base;
        logic [63:0] available_base;
        logic [63:0] used_base;
        logic        irq_raise;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  reg_index;
        logic [47:0] write_value;
    } t_cfg;

endpackage

// ----- rtl/vbm_chan_if.sv -----
// Valid/ready channel interface carrying one payload type.
// Payload types come from vbm_pkg.
interface vbm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/vbm_lane_merge.sv -----
// Byte-lane merge of a 1..4 byte write into a 32-bit register word.
// Also gives the unshifted masked write data used by the interrupt ack. No dependencies.
module vbm_lane_merge (
    input  logic [31:0] i_old,
    input  logic [1:0]  i_lane,
    input  logic [2:0]  i_count,
    input  logic [31:0] i_data,
    output logic [31:0] o_word,
    output logic [31:0] o_ack_mask
);
    logic [31:0] w_lane_mask;
    logic [31:0] w_mask;
    logic [31:0] w_val;

    always_comb begin
        case (i_count)
            3'd0:    w_lane_mask = 32'h0000_0000;
            3'd1:    w_lane_mask = 32'h0000_00ff;
            3'd2:    w_lane_mask = 32'h0000_ffff;
            3'd3:    w_lane_mask = 32'h00ff_ffff;
            default: w_lane_mask = 32'hffff_ffff;
        endcase
    end

    // bytes shifted past bit 31 drop out
    assign w_mask     = w_lane_mask << {i_lane, 3'b000};
    assign w_val      = (i_data & w_lane_mask) << {i_lane, 3'b000};
    assign o_word     = (i_old & ~w_mask) | (w_val & w_mask);
    assign o_ack_mask = i_data & w_lane_mask;
endmodule

// ----- rtl/virtio_block_mmio_registers_top.sv -----
// Top level of the virtio-mmio block device register front end.
// Uses vbm_pkg, vbm_chan_if and vbm_lane_merge.
//
//  channel  | dir | payload | transfer
//  i_req    | in  | t_req   | valid && ready: read, write or completion event
//  o_rsp    | out | t_rsp   | valid && ready: one result per request
//  i_cfg    | in  | t_cfg   | valid && ready: disk_present / capacity write
//
// One request per cycle unless o_rsp stalls: decode, byte merge and register
// update happen in the accept cycle, the result lands in one output register.
// i_req.ready is high while that register is empty or being drained, so a
// stalled o_rsp holds only one result. i_cfg is always ready. Synchronous
// active-low reset clears all device registers and the output valid.
module virtio_block_mmio_registers_top #(
    parameter int WINDOW_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    vbm_chan_if.sink            i_req,
    vbm_chan_if.source          o_rsp,
    vbm_chan_if.sink            i_cfg
);
    vbm_pkg::t_req  w_req;
    vbm_pkg::t_cfg  w_cfg;

    logic           r_disk_present,  n_disk_present;
    logic [47:0]    r_capacity,      n_capacity;
    logic [31:0]    r_dev_feat_sel,  n_dev_feat_sel;
    logic [31:0]    r_drv_feat_sel,  n_drv_feat_sel;
    logic [31:0]    r_drv_feat [2];
    logic [31:0]    n_drv_feat [2];
    logic [31:0]    r_q_sel,         n_q_sel;
    logic [3:0]     r_queue_size,    n_queue_size;
    logic           r_q_ready,       n_q_ready;
    logic [31:0]    r_status,        n_status;
    logic [31:0]    r_int_status,    n_int_status;
    logic [63:0]    r_desc_ring,     n_desc_ring;
    logic [63:0]    r_avail_addr,    n_avail_addr;
    logic [63:0]    r_used_addr,     n_used_addr;
    logic           r_rsp_valid,     n_rsp_valid;
    vbm_pkg::t_rsp  r_rsp,           n_rsp;

    logic           w_accept;
    logic           w_in_window;
    logic [11:0]    w_base;
    logic [31:0]    w_old;
    logic [31:0]    w_merged;
    logic [31:0]    w_ack_mask;
    logic           w_bell_ok;
    logic [31:0]    w_rd;

    assign w_req       = i_req.data;
    assign w_cfg       = i_cfg.data;
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_window = (32'(w_req.offset) < 32'(WINDOW_BYTES));
    assign w_base      = {w_req.offset[11:2], 2'b00};

    always_comb begin
        case (w_base)
            vbm_pkg::REG_DEV_FEAT_SEL: w_old = r_dev_feat_sel;
            vbm_pkg::REG_DRV_FEAT:     w_old = r_drv_feat[r_drv_feat_sel[0]];
            vbm_pkg::REG_DRV_FEAT_SEL: w_old = r_drv_feat_sel;
            vbm_pkg::REG_Q_SEL:        w_old = r_q_sel;
            vbm_pkg::REG_QUEUE_SIZE:   w_old = {28'd0, r_queue_size};
            vbm_pkg::REG_Q_READY:      w_old = {31'd0, r_q_ready};
            vbm_pkg::REG_STATUS:       w_old = r_status;
            vbm_pkg::REG_DESC_LO:      w_old = r_desc_ring[31:0];
            vbm_pkg::REG_DESC_HI:      w_old = r_desc_ring[63:32];
            vbm_pkg::REG_AVAIL_LO:     w_old = r_avail_addr[31:0];
            vbm_pkg::REG_AVAIL_HI:     w_old = r_avail_addr[63:32];
            vbm_pkg::REG_USED_LO:      w_old = r_used_addr[31:0];
            vbm_pkg::REG_USED_HI:      w_old = r_used_addr[63:32];
            default:                   w_old = 32'd0;
        endcase
    end

    vbm_lane_merge u_merge (
        .i_old      (w_old),
        .i_lane     (w_req.offset[1:0]),
        .i_count    (w_req.byte_count),
        .i_data     (w_req.write_data),
        .o_word     (w_merged),
        .o_ack_mask (w_ack_mask)
    );

    always_comb begin
        case (w_base)
            vbm_pkg::REG_MAGIC:       w_rd = vbm_pkg::MAGIC_WORD;
            vbm_pkg::REG_VERSION:     w_rd = vbm_pkg::MMIO_VERSION;
            vbm_pkg::REG_DEVICE_ID:   w_rd = r_disk_present ? vbm_pkg::BLOCK_DEVICE_ID : 32'd0;
            vbm_pkg::REG_VENDOR:      w_rd = vbm_pkg::VENDOR_WORD;
            vbm_pkg::REG_QUEUE_MAX:   w_rd = (r_disk_present && r_q_sel == 32'd0)
                                             ? {28'd0, vbm_pkg::QUEUE_MAX} : 32'd0;
            vbm_pkg::REG_Q_READY:     w_rd = {31'd0, r_q_ready};
            vbm_pkg::REG_INT_STATUS:  w_rd = r_int_status;
            vbm_pkg::REG_STATUS:      w_rd = r_status;
            vbm_pkg::REG_CAP_LO:      w_rd = r_capacity[31:0];
            vbm_pkg::REG_CAP_HI:      w_rd = {16'd0, r_capacity[47:32]};
            default:                  w_rd = 32'd0;
        endcase
    end

    assign w_bell_ok = r_disk_present && (r_q_sel == 32'd0) && r_q_ready
                    && r_status[vbm_pkg::STATUS_DRIVER_OK]
                    && (r_desc_ring != 64'd0) && (r_avail_addr != 64'd0)
                    && (r_used_addr != 64'd0);

    always_comb begin
        n_disk_present = r_disk_present;
        n_capacity     = r_capacity;
        n_dev_feat_sel = r_dev_feat_sel;
        n_drv_feat_sel = r_drv_feat_sel;
        n_drv_feat     = r_drv_feat;
        n_q_sel        = r_q_sel;
        n_queue_size   = r_queue_size;
        n_q_ready      = r_q_ready;
        n_status       = r_status;
        n_int_status   = r_int_status;
        n_desc_ring    = r_desc_ring;
        n_avail_addr   = r_avail_addr;
        n_used_addr    = r_used_addr;
        n_rsp_valid    = r_rsp_valid && !o_rsp.ready;
        n_rsp          = r_rsp;

        if (i_cfg.valid) begin
            if (w_cfg.reg_index == vbm_pkg::CFG_DISK_PRESENT) begin
                n_disk_present = w_cfg.write_value[0];
            end else if (w_cfg.reg_index == vbm_pkg::CFG_CAPACITY) begin
                n_capacity = w_cfg.write_value;
            end
        end

        if (w_accept) begin
            n_rsp_valid = 1'b1;
            n_rsp       = '0;
            case (w_req.kind)
                vbm_pkg::KIND_READ: begin
                    if (w_in_window) begin
                        n_rsp.read_data = w_rd;
                    end
                end
                vbm_pkg::KIND_WRITE: begin
                    if (w_in_window) begin
                        case (w_base)
                            vbm_pkg::REG_DEV_FEAT_SEL: n_dev_feat_sel = w_merged;
                            vbm_pkg::REG_DRV_FEAT:     n_drv_feat[r_drv_feat_sel[0]] = w_merged;
                            vbm_pkg::REG_DRV_FEAT_SEL: n_drv_feat_sel = w_merged;
                            vbm_pkg::REG_Q_SEL:        n_q_sel = w_merged;
                            vbm_pkg::REG_QUEUE_SIZE: begin
                                n_queue_size = (w_merged > {28'd0, vbm_pkg::QUEUE_MAX})
                                               ? vbm_pkg::QUEUE_MAX : w_merged[3:0];
                            end
                            vbm_pkg::REG_Q_READY:      n_q_ready = w_merged[0];
                            vbm_pkg::REG_NOTIFY: begin
                                if (w_bell_ok) begin
                                    n_rsp.doorbell        = 1'b1;
                                    n_rsp.queue_entries   = (r_queue_size == 4'd0)
                                                            ? vbm_pkg::QUEUE_MAX : r_queue_size;
                                    n_rsp.descriptor_base = r_desc_ring;
                                    n_rsp.available_base  = r_avail_addr;
                                    n_rsp.used_base       = r_used_addr;
                                end
                            end
                            vbm_pkg::REG_INT_ACK:  n_int_status = r_int_status & ~w_ack_mask;
                            vbm_pkg::REG_STATUS: begin
                                n_status = w_merged;
                                if (w_merged == 32'd0) begin
                                    n_dev_feat_sel = '0;
                                    n_drv_feat_sel = '0;
                                    n_drv_feat[0]  = '0;
                                    n_drv_feat[1]  = '0;
                                    n_q_sel        = '0;
                                    n_queue_size   = '0;
                                    n_q_ready      = 1'b0;
                                    n_int_status   = '0;
                                    n_desc_ring    = '0;
                                    n_avail_addr   = '0;
                                    n_used_addr    = '0;
                                end
                            end
                            vbm_pkg::REG_DESC_LO:  n_desc_ring[31:0]   = w_merged;
                            vbm_pkg::REG_DESC_HI:  n_desc_ring[63:32]  = w_merged;
                            vbm_pkg::REG_AVAIL_LO: n_avail_addr[31:0]  = w_merged;
                            vbm_pkg::REG_AVAIL_HI: n_avail_addr[63:32] = w_merged;
                            vbm_pkg::REG_USED_LO:  n_used_addr[31:0]   = w_merged;
                            vbm_pkg::REG_USED_HI:  n_used_addr[63:32]  = w_merged;
                            default: ;
                        endcase
                    end
                end
                vbm_pkg::KIND_DONE: begin
                    n_int_status    = r_int_status | 32'd1;
                    n_rsp.irq_raise = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_present <= 1'b0;
            r_capacity     <= '0;
            r_dev_feat_sel <= '0;
            r_drv_feat_sel <= '0;
            r_drv_feat[0]  <= '0;
            r_drv_feat[1]  <= '0;
            r_q_sel        <= '0;
            r_queue_size   <= '0;
            r_q_ready      <= 1'b0;
            r_status       <= '0;
            r_int_status   <= '0;
            r_desc_ring    <= '0;
            r_avail_addr   <= '0;
            r_used_addr    <= '0;
            r_rsp_valid    <= 1'b0;
        end else begin
            r_disk_present <= n_disk_present;
            r_capacity     <= n_capacity;
            r_dev_feat_sel <= n_dev_feat_sel;
            r_drv_feat_sel <= n_drv_feat_sel;
            r_drv_feat     <= n_drv_feat;
            r_q_sel        <= n_q_sel;
            r_queue_size   <= n_queue_size;
            r_q_ready      <= n_q_ready;
            r_status       <= n_status;
            r_int_status   <= n_int_status;
            r_desc_ring    <= n_desc_ring;
            r_avail_addr   <= n_avail_addr;
            r_used_addr    <= n_used_addr;
            r_rsp_valid    <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end
endmodule
